// ----- sv/iso_timestamp_to_epoch_ms_core_macros.svh -----
// Assertion macros shared by the timestamp converter.
`ifndef ISO_TIMESTAMP_TO_EPOCH_MS_CORE_MACROS_SVH
`define ISO_TIMESTAMP_TO_EPOCH_MS_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/iso_ts_pkg.sv -----
// Types, constants and lookup functions for the timestamp converter.
`default_nettype none

package iso_ts_pkg;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Field indexes of the date and time scan.
    localparam logic [2:0] FLD_YEAR   = 3'd0;
    localparam logic [2:0] FLD_MONTH  = 3'd1;
    localparam logic [2:0] FLD_DAY    = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_MINUTE = 3'd4;
    localparam logic [2:0] FLD_SECOND = 3'd5;

    // Position from which the fraction and the zone may start.
    localparam logic [4:0] TAIL_START = 5'd19;
    localparam logic [4:0] POS_MAX    = 5'd31;

    // Zone designator progress.
    typedef enum logic [1:0] {
        TAIL_NONE    = 2'd0,
        TAIL_DONE    = 2'd1,
        TAIL_HOURS   = 2'd2,
        TAIL_MINUTES = 2'd3
    } tail_phase_t;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Arithmetic constants.
    localparam int unsigned YEAR_MIN      = 1970;
    localparam int unsigned YEAR_MAX      = 3000;
    localparam int unsigned RECIP_100     = 5243;   // 2^19 / 100, rounded up
    localparam int unsigned RECIP_SHIFT   = 19;
    localparam int unsigned EPOCH_DAYS    = 719468; // days from 0000-03-01 to 1970-01-01
    localparam int unsigned MS_PER_DAY    = 86400000;
    localparam int unsigned MS_PER_MINUTE = 60000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic parse;
        logic clear;
        logic capture1;
        logic capture2;
        logic capture3;
        logic capture4;
        logic load_out;
    } dp_cmd_t;

    // Separator expected after a field.
    function automatic logic [7:0] sep_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            FLD_YEAR, FLD_MONTH: c = CH_DASH;
            FLD_DAY:             c = CH_T;
            default:             c = CH_COLON;
        endcase
        return c;
    endfunction

    // Days in a month, month given as 1..12.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd2:                      n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    // Day of a March-based year on which a month starts.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd306;
            4'd2:    d = 9'd337;
            4'd3:    d = 9'd0;
            4'd4:    d = 9'd31;
            4'd5:    d = 9'd61;
            4'd6:    d = 9'd92;
            4'd7:    d = 9'd122;
            4'd8:    d = 9'd153;
            4'd9:    d = 9'd184;
            4'd10:   d = 9'd214;
            4'd11:   d = 9'd245;
            default: d = 9'd275;
        endcase
        return d;
    endfunction

    // Decimal accumulate with a cap of 99.
    function automatic logic [6:0] sat_add99(input logic [6:0] acc, input logic [3:0] d);
        logic [9:0] v;
        v = 10'(acc) * 10'd10 + 10'(d);
        return (v > 10'd99) ? 7'd99 : v[6:0];
    endfunction

    // Decimal accumulate with a cap of 9999.
    function automatic logic [13:0] sat_add9999(input logic [13:0] acc, input logic [3:0] d);
        logic [16:0] v;
        v = 17'(acc) * 17'd10 + 17'(d);
        return (v > 17'd9999) ? 14'd9999 : v[13:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/iso_timestamp_to_epoch_ms_core.sv -----
// ISO 8601 timestamp to UTC epoch milliseconds: one character per cycle, then an epoch result.
// Throughput: one character is taken in every cycle while a timestamp is being scanned.
// The result is loaded after the check, prep, sum and multiply states that follow the final character.
// Input is held off until the result is loaded, longer while the previous result is not yet taken.
// Reset (rst_n low, asynchronous) clears the scanner and drops any pending result.
`default_nettype none
`include "iso_timestamp_to_epoch_ms_core_macros.svh"

module iso_timestamp_to_epoch_ms_core
    import iso_ts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Character stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last_char
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // [45:0] epoch_ms, [47:46] status
);

    // The controller steps the datapath: it scans characters while in its
    // parse state and, after the final character, walks the four arithmetic
    // stages before loading the result register. A loaded result waits in
    // that register while the next timestamp is already being scanned.
    dp_cmd_t            cmd;
    logic signed [45:0] epoch_ms;
    logic [1:0]         status;

    iso_ts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    iso_ts_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .char_code (s_tdata),
        .epoch_ms  (epoch_ms),
        .status    (status)
    );

    assign m_tdata = {status, epoch_ms};

    // After the final character of a request the input must stay closed
    // while the conversion runs.
    `ITE_ASSERT_NEXT(a_last_blocks_input, s_tvalid && s_tready && s_tlast, !s_tready,
        "input accepted during conversion")

    // A result is loaded only when the output register is empty or draining.
    `ITE_ASSERT_SAME(a_load_when_free, cmd.load_out, !m_tvalid || m_tready,
        "result register overwritten")

    // Any error status carries a zero epoch value.
    `ITE_ASSERT_SAME(a_error_is_zero, m_tvalid && (m_tdata[47:46] != STATUS_OK),
        m_tdata[45:0] == 46'd0, "error result with nonzero epoch")

endmodule

`default_nettype wire

// ----- sv/iso_ts_ctrl.sv -----
// Controller state machine of the timestamp converter.
`default_nettype none

module iso_ts_ctrl
    import iso_ts_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    input  wire logic    s_tlast,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output dp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_PARSE,
        ST_CHECK,
        ST_PREP,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_PARSE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            ST_PARSE:
            begin
                cmd.parse = s_tvalid;
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.capture1 = 1'b1;
                cmd.clear    = 1'b1;
                state_next   = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.capture2 = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.capture3 = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.capture4 = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_PARSE;
                end
            end
            default:
            begin
                state_next = ST_PARSE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_PARSE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/iso_ts_dp.sv -----
// Datapath of the timestamp converter: character scanner and epoch arithmetic.
`default_nettype none

module iso_ts_dp
    import iso_ts_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire dp_cmd_t      cmd,
    input  wire logic [7:0]   char_code,
    output logic signed [45:0] epoch_ms,
    output logic [1:0]        status
);

    // Scanner state.
    logic [4:0]  char_pos_reg, char_pos_next;
    logic [2:0]  field_idx_reg, field_idx_next;
    tail_phase_t tail_phase_reg, tail_phase_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [9:0]  frac_ms_reg, frac_ms_next;
    logic [1:0]  frac_digits_reg, frac_digits_next;
    logic        off_neg_reg, off_neg_next;
    logic [6:0]  off_hours_reg, off_hours_next;
    logic [6:0]  off_minutes_reg, off_minutes_next;
    logic        has_digit_reg, has_digit_next;
    logic        field_stop_reg, field_stop_next;
    logic        dot_seen_reg, dot_seen_next;
    logic        frac_stop_reg, frac_stop_next;
    logic        off_valid_reg, off_valid_next;

    logic       is_digit, is_blank, in_tail;
    logic [3:0] dv;
    logic [9:0] frac_add;

    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_blank = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
    assign in_tail  = (char_pos_reg >= TAIL_START);
    assign dv       = char_code[3:0];

    always_comb
    begin
        case (frac_digits_reg)
            2'd0:    frac_add = 10'(dv) * 10'd100;
            2'd1:    frac_add = 10'(dv) * 10'd10;
            default: frac_add = 10'(dv);
        endcase
    end

    always_comb
    begin
        char_pos_next    = char_pos_reg;
        field_idx_next   = field_idx_reg;
        tail_phase_next  = tail_phase_reg;
        year_next        = year_reg;
        month_next       = month_reg;
        day_next         = day_reg;
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        second_next      = second_reg;
        frac_ms_next     = frac_ms_reg;
        frac_digits_next = frac_digits_reg;
        off_neg_next     = off_neg_reg;
        off_hours_next   = off_hours_reg;
        off_minutes_next = off_minutes_reg;
        has_digit_next   = has_digit_reg;
        field_stop_next  = field_stop_reg;
        dot_seen_next    = dot_seen_reg;
        frac_stop_next   = frac_stop_reg;
        off_valid_next   = off_valid_reg;

        if (cmd.clear)
        begin
            char_pos_next    = '0;
            field_idx_next   = FLD_YEAR;
            tail_phase_next  = TAIL_NONE;
            year_next        = '0;
            month_next       = '0;
            day_next         = '0;
            hour_next        = '0;
            minute_next      = '0;
            second_next      = '0;
            frac_ms_next     = '0;
            frac_digits_next = '0;
            off_neg_next     = 1'b0;
            off_hours_next   = '0;
            off_minutes_next = '0;
            has_digit_next   = 1'b0;
            field_stop_next  = 1'b0;
            dot_seen_next    = 1'b0;
            frac_stop_next   = 1'b0;
            off_valid_next   = 1'b0;
        end
        else if (cmd.parse)
        begin
            // Date and time fields.
            if (!field_stop_reg)
            begin
                if (is_digit)
                begin
                    has_digit_next = 1'b1;
                    case (field_idx_reg)
                        FLD_YEAR:   year_next   = sat_add9999(year_reg, dv);
                        FLD_MONTH:  month_next  = sat_add99(month_reg, dv);
                        FLD_DAY:    day_next    = sat_add99(day_reg, dv);
                        FLD_HOUR:   hour_next   = sat_add99(hour_reg, dv);
                        FLD_MINUTE: minute_next = sat_add99(minute_reg, dv);
                        default:    second_next = sat_add99(second_reg, dv);
                    endcase
                end
                else if (!has_digit_reg && is_blank)
                begin
                    // Leading blanks of a field are skipped.
                end
                else if (has_digit_reg && (field_idx_reg < FLD_SECOND)
                         && (char_code == sep_char(field_idx_reg)))
                begin
                    field_idx_next = field_idx_reg + 3'd1;
                    has_digit_next = 1'b0;
                end
                else
                begin
                    field_stop_next = 1'b1;
                end
            end

            // Fractional seconds.
            if (dot_seen_reg)
            begin
                if (!frac_stop_reg)
                begin
                    if (is_digit && (frac_digits_reg != 2'd3))
                    begin
                        frac_ms_next     = frac_ms_reg + frac_add;
                        frac_digits_next = frac_digits_reg + 2'd1;
                    end
                    else
                    begin
                        frac_stop_next = 1'b1;
                    end
                end
            end
            else if (in_tail && (char_code == CH_DOT))
            begin
                dot_seen_next = 1'b1;
            end

            // Zone designator and offset.
            case (tail_phase_reg)
                TAIL_NONE:
                begin
                    if (in_tail && (char_code == CH_Z))
                    begin
                        tail_phase_next = TAIL_DONE;
                    end
                    else if (in_tail && ((char_code == CH_PLUS) || (char_code == CH_DASH)))
                    begin
                        tail_phase_next = TAIL_HOURS;
                        off_neg_next    = (char_code == CH_DASH);
                    end
                end
                TAIL_HOURS:
                begin
                    if (is_digit)
                    begin
                        off_hours_next = sat_add99(off_hours_reg, dv);
                        off_valid_next = 1'b1;
                    end
                    else if (off_valid_reg && (char_code == CH_COLON))
                    begin
                        tail_phase_next = TAIL_MINUTES;
                    end
                    else
                    begin
                        tail_phase_next = TAIL_DONE;
                    end
                end
                TAIL_MINUTES:
                begin
                    if (is_digit)
                    begin
                        off_minutes_next = sat_add99(off_minutes_reg, dv);
                    end
                    else
                    begin
                        tail_phase_next = TAIL_DONE;
                    end
                end
                default:
                begin
                end
            endcase

            if (char_pos_reg != POS_MAX)
            begin
                char_pos_next = char_pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_pos_reg    <= '0;
            field_idx_reg   <= FLD_YEAR;
            tail_phase_reg  <= TAIL_NONE;
            year_reg        <= '0;
            month_reg       <= '0;
            day_reg         <= '0;
            hour_reg        <= '0;
            minute_reg      <= '0;
            second_reg      <= '0;
            frac_ms_reg     <= '0;
            frac_digits_reg <= '0;
            off_neg_reg     <= 1'b0;
            off_hours_reg   <= '0;
            off_minutes_reg <= '0;
            has_digit_reg   <= 1'b0;
            field_stop_reg  <= 1'b0;
            dot_seen_reg    <= 1'b0;
            frac_stop_reg   <= 1'b0;
            off_valid_reg   <= 1'b0;
        end
        else
        begin
            char_pos_reg    <= char_pos_next;
            field_idx_reg   <= field_idx_next;
            tail_phase_reg  <= tail_phase_next;
            year_reg        <= year_next;
            month_reg       <= month_next;
            day_reg         <= day_next;
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            second_reg      <= second_next;
            frac_ms_reg     <= frac_ms_next;
            frac_digits_reg <= frac_digits_next;
            off_neg_reg     <= off_neg_next;
            off_hours_reg   <= off_hours_next;
            off_minutes_reg <= off_minutes_next;
            has_digit_reg   <= has_digit_next;
            field_stop_reg  <= field_stop_next;
            dot_seen_reg    <= dot_seen_next;
            frac_stop_reg   <= frac_stop_next;
            off_valid_reg   <= off_valid_next;
        end
    end

    // Stage 1: range check, leap year, March-based year and day of year.
    logic [11:0] yr12;
    logic [24:0] yr_recip;
    logic [5:0]  yr_q100;
    logic [11:0] yr_r100;
    logic        leap;
    logic [3:0]  field_count;
    logic        range_bad;
    logic [1:0]  st1_status_next;
    logic [11:0] st1_yy_next;
    logic [8:0]  st1_dd_next;

    assign yr12     = year_reg[11:0];
    assign yr_recip = 25'(yr12) * 25'(RECIP_100);
    assign yr_q100  = yr_recip[24:RECIP_SHIFT];
    assign yr_r100  = yr12 - 12'(yr_q100) * 12'd100;
    assign leap     = (yr12[1:0] == 2'd0) && ((yr_r100 != 12'd0) || (yr_q100[1:0] == 2'd0));

    assign field_count = 4'(field_idx_reg) + 4'(has_digit_reg);
    assign range_bad = (year_reg < 14'(YEAR_MIN)) || (year_reg > 14'(YEAR_MAX))
                    || (month_reg < 7'd1) || (month_reg > 7'd12)
                    || (day_reg < 7'd1) || (day_reg > 7'(month_len(month_reg[3:0], leap)))
                    || (hour_reg > 7'd23) || (minute_reg > 7'd59) || (second_reg > 7'd59);

    always_comb
    begin
        if (field_count < 4'd6)
        begin
            st1_status_next = STATUS_SHORT;
        end
        else if (range_bad)
        begin
            st1_status_next = STATUS_RANGE;
        end
        else
        begin
            st1_status_next = STATUS_OK;
        end
    end

    assign st1_yy_next = yr12 - ((month_reg <= 7'd2) ? 12'd1 : 12'd0);
    assign st1_dd_next = month_start(month_reg[3:0]) + 9'(day_reg) - 9'd1;

    logic [1:0]  st1_status_reg;
    logic [11:0] st1_yy_reg;
    logic [8:0]  st1_dd_reg;
    logic [4:0]  st1_hour_reg;
    logic [5:0]  st1_minute_full_reg, st1_second_full_reg;
    logic [9:0]  st1_frac_reg;
    logic        st1_off_neg_reg, st1_off_valid_reg;
    logic [6:0]  st1_off_hours_reg, st1_off_minutes_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture1)
        begin
            st1_status_reg      <= st1_status_next;
            st1_yy_reg          <= st1_yy_next;
            st1_dd_reg          <= st1_dd_next;
            st1_hour_reg        <= hour_reg[4:0];
            st1_minute_full_reg <= minute_reg[5:0];
            st1_second_full_reg <= second_reg[5:0];
            st1_frac_reg        <= frac_ms_reg;
            st1_off_neg_reg     <= off_neg_reg;
            st1_off_valid_reg   <= off_valid_reg;
            st1_off_hours_reg   <= off_hours_reg;
            st1_off_minutes_reg <= off_minutes_reg;
        end
    end

    // Stage 2: year products, seconds of day, offset in minutes.
    logic [20:0] st2_yy365_next;
    logic [24:0] yy_recip;
    logic [16:0] st2_hms_next;
    logic [12:0] st2_offm_next;

    assign st2_yy365_next = 21'(st1_yy_reg) * 21'd365;
    assign yy_recip       = 25'(st1_yy_reg) * 25'(RECIP_100);
    assign st2_hms_next   = 17'(st1_hour_reg) * 17'd3600 + 17'(st1_minute_full_reg) * 17'd60
                          + 17'(st1_second_full_reg);
    assign st2_offm_next  = st1_off_valid_reg
                          ? (13'(st1_off_hours_reg) * 13'd60 + 13'(st1_off_minutes_reg))
                          : 13'd0;

    logic [1:0]  st2_status_reg;
    logic [11:0] st2_yy_reg;
    logic [20:0] st2_yy365_reg;
    logic [5:0]  st2_q100_reg;
    logic [8:0]  st2_dd_reg;
    logic [16:0] st2_hms_reg;
    logic [9:0]  st2_frac_reg;
    logic        st2_off_neg_reg;
    logic [12:0] st2_offm_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture2)
        begin
            st2_status_reg  <= st1_status_reg;
            st2_yy_reg      <= st1_yy_reg;
            st2_yy365_reg   <= st2_yy365_next;
            st2_q100_reg    <= yy_recip[24:RECIP_SHIFT];
            st2_dd_reg      <= st1_dd_reg;
            st2_hms_reg     <= st2_hms_next;
            st2_frac_reg    <= st1_frac_reg;
            st2_off_neg_reg <= st1_off_neg_reg;
            st2_offm_reg    <= st2_offm_next;
        end
    end

    // Stage 3: day count, milliseconds of day, offset in milliseconds.
    logic [21:0] days_sum;
    logic [26:0] st3_hms_ms_next;
    logic [28:0] st3_off_ms_next;

    assign days_sum = 22'(st2_yy365_reg) + 22'(st2_yy_reg[11:2]) - 22'(st2_q100_reg)
                    + 22'(st2_q100_reg[5:2]) + 22'(st2_dd_reg) - 22'(EPOCH_DAYS);
    assign st3_hms_ms_next = 27'(st2_hms_reg) * 27'd1000 + 27'(st2_frac_reg);
    assign st3_off_ms_next = 29'(st2_offm_reg) * 29'(MS_PER_MINUTE);

    logic [1:0]  st3_status_reg;
    logic [18:0] st3_days_reg;
    logic [26:0] st3_hms_ms_reg;
    logic [28:0] st3_off_ms_reg;
    logic        st3_off_neg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture3)
        begin
            st3_status_reg  <= st2_status_reg;
            st3_days_reg    <= days_sum[18:0];
            st3_hms_ms_reg  <= st3_hms_ms_next;
            st3_off_ms_reg  <= st3_off_ms_next;
            st3_off_neg_reg <= st2_off_neg_reg;
        end
    end

    // Stage 4: milliseconds of the date and local time less offset.
    logic [45:0]        st4_prod_next;
    logic signed [29:0] st4_loc_next;

    assign st4_prod_next = 46'(st3_days_reg) * 46'(MS_PER_DAY);
    assign st4_loc_next  = st3_off_neg_reg
                         ? signed'(30'(st3_hms_ms_reg) + 30'(st3_off_ms_reg))
                         : signed'(30'(st3_hms_ms_reg) - 30'(st3_off_ms_reg));

    logic [1:0]         st4_status_reg;
    logic [45:0]        st4_prod_reg;
    logic signed [29:0] st4_loc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture4)
        begin
            st4_status_reg <= st3_status_reg;
            st4_prod_reg   <= st4_prod_next;
            st4_loc_reg    <= st4_loc_next;
        end
    end

    // Output register.
    logic signed [45:0] epoch_next;
    logic signed [45:0] epoch_reg;
    logic [1:0]         status_reg;

    assign epoch_next = (st4_status_reg == STATUS_OK)
                      ? signed'(st4_prod_reg + {{16{st4_loc_reg[29]}}, st4_loc_reg})
                      : 46'sd0;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            epoch_reg  <= epoch_next;
            status_reg <= st4_status_reg;
        end
    end

    assign epoch_ms = epoch_reg;
    assign status   = status_reg;

endmodule

`default_nettype wire

// ----- test/epoch_ms_checker.sv -----
// Checker for the timestamp converter: predicts every epoch result and compares it.
module epoch_ms_checker
    import iso_ts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [45:0] epoch_ms, [47:46] status
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [45:0] epoch_ms;
    } stamp_result_t;

    stamp_result_t expected_stamps[$];
    stamp_result_t got;
    stamp_result_t want;
    int            mismatches = 0;
    int            queued = 0;

    // Shadow of the scanner.
    logic [4:0]  pos_q;
    logic [2:0]  fld_q;
    tail_phase_t zone_q;
    logic [13:0] year_q;
    logic [6:0]  mon_q, day_q, hour_q, min_q, sec_q;
    logic [9:0]  frac_q;
    logic [1:0]  frac_n_q;
    logic        off_neg_q;
    logic [6:0]  off_h_q, off_m_q;
    logic        digit_seen_q, scan_done_q, dot_q, frac_done_q, off_ok_q;

    assign fail_count = mismatches;
    assign pending    = queued;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic int push_digit(input int acc, input int d, input int cap);
        int v;
        v = acc * 10 + d;
        return (v > cap) ? cap : v;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] sep_after(input logic [2:0] idx);
        if (idx < FLD_DAY)
            return CH_DASH;
        return (idx == FLD_DAY) ? CH_T : CH_COLON;
    endfunction

    function automatic int days_in_month(input int y, input int m);
        logic leap;
        leap = (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
        if (m == 2)
            return leap ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Days from 1970-01-01 in the proleptic Gregorian calendar.
    function automatic longint civil_days(input int y, input int m, input int d);
        longint yy, era, yoe, mp, doy, doe;
        yy  = y - ((m <= 2) ? 1 : 0);
        era = yy / 400;
        yoe = yy - era * 400;
        mp  = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - longint'(EPOCH_DAYS);
    endfunction

    task automatic clear_scan();
        pos_q        = '0;
        fld_q        = FLD_YEAR;
        zone_q       = TAIL_NONE;
        year_q       = '0;
        mon_q        = '0;
        day_q        = '0;
        hour_q       = '0;
        min_q        = '0;
        sec_q        = '0;
        frac_q       = '0;
        frac_n_q     = '0;
        off_neg_q    = 1'b0;
        off_h_q      = '0;
        off_m_q      = '0;
        digit_seen_q = 1'b0;
        scan_done_q  = 1'b0;
        dot_q        = 1'b0;
        frac_done_q  = 1'b0;
        off_ok_q     = 1'b0;
    endtask

    // Advances the shadow scanner by one character; the final one queues a result.
    task automatic parse_char(input logic [7:0] c, input logic is_last);
        logic          is_dig, in_tail, bad_date;
        int            dv, scale;
        longint        secs, off, ms;
        stamp_result_t r;

        is_dig  = (c >= CH_ZERO && c <= CH_NINE);
        dv      = int'(c) - int'(CH_ZERO);
        in_tail = (pos_q >= TAIL_START);

        if (!scan_done_q) begin
            if (is_dig) begin
                case (fld_q)
                    FLD_YEAR:   year_q = 14'(push_digit(int'(year_q), dv, 9999));
                    FLD_MONTH:  mon_q  = 7'(push_digit(int'(mon_q), dv, 99));
                    FLD_DAY:    day_q  = 7'(push_digit(int'(day_q), dv, 99));
                    FLD_HOUR:   hour_q = 7'(push_digit(int'(hour_q), dv, 99));
                    FLD_MINUTE: min_q  = 7'(push_digit(int'(min_q), dv, 99));
                    default:    sec_q  = 7'(push_digit(int'(sec_q), dv, 99));
                endcase
                digit_seen_q = 1'b1;
            end else if (digit_seen_q && fld_q < FLD_SECOND && c == sep_after(fld_q)) begin
                fld_q++;
                digit_seen_q = 1'b0;
            end else if (digit_seen_q || !is_blank(c)) begin
                scan_done_q = 1'b1;
            end
        end

        if (dot_q) begin
            if (!frac_done_q) begin
                if (is_dig && frac_n_q < 2'd3) begin
                    scale    = (frac_n_q == 2'd0) ? 100 : ((frac_n_q == 2'd1) ? 10 : 1);
                    frac_q   = 10'(int'(frac_q) + dv * scale);
                    frac_n_q = frac_n_q + 2'd1;
                end else begin
                    frac_done_q = 1'b1;
                end
            end
        end else if (in_tail && c == CH_DOT) begin
            dot_q = 1'b1;
        end

        case (zone_q)
            TAIL_NONE: begin
                if (in_tail && c == CH_Z) begin
                    zone_q = TAIL_DONE;
                end else if (in_tail && (c == CH_PLUS || c == CH_DASH)) begin
                    zone_q    = TAIL_HOURS;
                    off_neg_q = (c == CH_DASH);
                end
            end
            TAIL_HOURS: begin
                if (is_dig) begin
                    off_h_q  = 7'(push_digit(int'(off_h_q), dv, 99));
                    off_ok_q = 1'b1;
                end else if (off_ok_q && c == CH_COLON) begin
                    zone_q = TAIL_MINUTES;
                end else begin
                    zone_q = TAIL_DONE;
                end
            end
            TAIL_MINUTES: begin
                if (is_dig)
                    off_m_q = 7'(push_digit(int'(off_m_q), dv, 99));
                else
                    zone_q = TAIL_DONE;
            end
            default: ;
        endcase

        if (pos_q < POS_MAX)
            pos_q = pos_q + 5'd1;

        if (is_last) begin
            ms       = 0;
            r.status = STATUS_OK;
            bad_date = year_q < YEAR_MIN || year_q > YEAR_MAX ||
                       mon_q < 7'd1 || mon_q > 7'd12 || day_q < 7'd1 ||
                       int'(day_q) > days_in_month(int'(year_q), int'(mon_q)) ||
                       hour_q > 7'd23 || min_q > 7'd59 || sec_q > 7'd59;
            if (int'(fld_q) + int'(digit_seen_q) < 6) begin
                r.status = STATUS_SHORT;
            end else if (bad_date) begin
                r.status = STATUS_RANGE;
            end else begin
                secs = civil_days(int'(year_q), int'(mon_q), int'(day_q)) * 86400 +
                       longint'(hour_q) * 3600 + longint'(min_q) * 60 + longint'(sec_q);
                off = 0;
                if (off_ok_q) begin
                    off = longint'(off_h_q) * 60 + longint'(off_m_q);
                    if (off_neg_q)
                        off = -off;
                end
                ms = secs * 1000 + longint'(frac_q) - off * longint'(MS_PER_MINUTE);
            end
            r.epoch_ms = ms[45:0];
            expected_stamps.push_back(r);
            clear_scan();
        end
    endtask

    initial clear_scan();

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_stamps.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: status %0d epoch_ms %0d",
                                              got.status, $signed(got.epoch_ms)));
                end else begin
                    want = expected_stamps.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.epoch_ms !== want.epoch_ms)
                        report_mismatch($sformatf("epoch_ms %0d, expected %0d",
                                                  $signed(got.epoch_ms),
                                                  $signed(want.epoch_ms)));
                end
            end
            if (s_tvalid && s_tready)
                parse_char(s_tdata, s_tlast);
            queued = expected_stamps.size();
        end
    end

endmodule

// ----- test/tb.sv -----
// Top of the timestamp converter testbench: clock, reset, character stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iso_ts_pkg::*;

    // Run shape. The cycle limit is many times the slowest legal run: every
    // character waiting the longest gap, every result its latency plus the
    // longest receiver stall, and the long hold-off on top.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int CHAR_TARGET  = 850;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] char_code
    logic        s_tlast;    // last_char
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // [45:0] epoch_ms, [47:46] status

    int fail_count;
    int pending;

    // Characters of the timestamp that is being built, sent as one string.
    byte unsigned text_q[$];
    string        syntax_chars = "0123456789-T:.Z+ \t";

    int   chars_sent  = 0;
    int   cycle_count = 0;
    logic src_burst   = 1'b0;

    // Receiver state: a per-result wait, a no-wait mode and the long hold-off.
    int   sink_wait = 0;
    logic sink_fast = 1'b0;
    logic long_hold = 1'b0;
    logic hold_go   = 1'b0;

    iso_timestamp_to_epoch_ms_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    epoch_ms_checker stamp_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The wait for the next result only counts down while a result is on
    // offer, so the gap really lands on a waiting result and not on idle time.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if ($urandom_range(0, 7) == 0)
                    sink_fast <= ~sink_fast;
                sink_wait <= sink_fast ? 0 : $urandom_range(0, 6);
            end
            else if (m_tvalid && sink_wait > 0)
            begin
                sink_wait <= sink_wait - 1;
            end
        end
    end

    always @(negedge clk)
        m_tready <= rst_n && !long_hold && (sink_wait == 0);

    // One long stall of the result side while the sender keeps offering
    // characters: the finished result stays put and the block must hold
    // its character input off until the stall ends.
    initial
    begin
        wait (hold_go);
        @(negedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold <= 1'b0;
    end

    // Watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Offers one character request after a random gap (none in burst mode) and waits until it is taken.
    task automatic send_char(input logic [7:0] c, input logic is_last);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 6);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= is_last;
        do @(posedge clk); while (!s_tready);
        chars_sent++;
    endtask

    // Sends the buffered string, flagging its final character, then empties the buffer.
    task automatic send_text();
        src_burst = ($urandom_range(0, 3) == 0);
        foreach (text_q[i])
            send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic put_num(input int value, input int width);
        string digits;
        digits = $sformatf("%0d", value);
        while (digits.len() < width)
            digits = {"0", digits};
        put_str(digits);
    endtask

    // Holds the sender back until every result that is owed has come out.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        while (pending != 0);
    endtask

    // Builds one random string. Most are well-formed timestamps with random
    // content, so that the fraction and zone logic past position 19 is reached;
    // the rest are noise, junk tails and damaged strings.
    task automatic make_random_stamp();
        int pick, n, year, month, day, hour, minute, second, zone;

        pick = $urandom_range(0, 9);
        if (pick >= 8)
        begin
            n = $urandom_range(1, 30);
            repeat (n)
            begin
                if ($urandom_range(0, 1) != 0)
                    text_q.push_back(8'($urandom));
                else
                    text_q.push_back(syntax_chars[$urandom_range(0, syntax_chars.len() - 1)]);
            end
            return;
        end

        case ($urandom_range(0, 19))
            0:       year = $urandom_range(0, 1969);
            1:       year = $urandom_range(3001, 99999);
            2:       year = ($urandom_range(0, 1) != 0) ? YEAR_MIN : YEAR_MAX;
            default: year = $urandom_range(YEAR_MIN, YEAR_MAX);
        endcase
        month  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
        case ($urandom_range(0, 9))
            0:       day = $urandom_range(0, 99);
            1, 2:    day = $urandom_range(28, 31);
            default: day = $urandom_range(1, 28);
        endcase
        hour   = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 99) : $urandom_range(0, 23);
        minute = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
        second = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);

        if ($urandom_range(0, 7) == 0)
            put_str(" ");
        put_num(year, 4);
        put_str("-");
        put_num(month, ($urandom_range(0, 4) == 0) ? 1 : 2);
        put_str("-");
        if ($urandom_range(0, 15) == 0)
            put_str("\t");
        put_num(day, ($urandom_range(0, 4) == 0) ? 1 : 2);
        put_str("T");
        put_num(hour, ($urandom_range(0, 4) == 0) ? 1 : 2);
        put_str(":");
        put_num(minute, 2);
        put_str(":");
        put_num(second, ($urandom_range(0, 5) == 0) ? 1 : 2);

        if ($urandom_range(0, 1) != 0)
        begin
            put_str(".");
            repeat ($urandom_range(0, 4))
                put_num($urandom_range(0, 9), 1);
        end

        zone = $urandom_range(0, 7);
        case (zone)
            0: ;
            1, 6: put_str("Z");
            2, 3, 5:
            begin
                put_str(($urandom_range(0, 1) != 0) ? "+" : "-");
                if ($urandom_range(0, 7) == 0)
                    put_num($urandom_range(0, 999), 3);
                else
                    put_num($urandom_range(0, 14), $urandom_range(1, 2));
                if (zone != 5)
                begin
                    put_str(":");
                    if ($urandom_range(0, 5) != 0)
                        put_num($urandom_range(0, 99), $urandom_range(1, 3));
                end
            end
            4: put_str(($urandom_range(0, 1) != 0) ? "+" : "-");
            default: put_str("Z+01:00");
        endcase

        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 12))
                text_q.push_back(syntax_chars[$urandom_range(0, syntax_chars.len() - 1)]);
        end

        // Damaged strings: cut short or with one character replaced.
        if (pick == 7)
        begin
            if ($urandom_range(0, 1) != 0)
                text_q = text_q[0:$urandom_range(0, text_q.size() - 1)];
            else
                text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
        end
    endtask

    string directed_cases[] = '{
        "1970-01-01T00:00:00Z",
        "3000-12-31T23:59:59.999-99:99",
        "1970-01-01T00:00:00.000+999:999",
        "2000-02-29T12:34:56.7+05:30",
        "2100-02-29T00:00:00Z",
        "1969-12-31T23:59:59Z",
        "2024-13-31T00:00:00",
        "2024-04-31T23:59:60",
        "2024-02-00T00:00:00",
        "\n2024-\t06-\01515T\01310:20:\01430.12345Z",
        "2024-1-5T7:8:9.5Z",
        "2024-06-15T10:20",
        "99999-01-01T00:00:00",
        "2024-06-15T10:20:30.",
        "2024-06-15T10:20:30+",
        "2024-06-15T10:20:30-05",
        "2024-06-15T10:20:30+05:",
        "2024-06-15T10:20:30.5Z+01:00 and text past the end",
        "2024-06-15T10:20:30",
        "2024-06-15x"
    };

    initial
    begin
        int round;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed strings: calendar and epoch extremes, leap rules, blanks,
        // saturating fields, short strings, empty fraction and offset forms.
        foreach (directed_cases[i])
        begin
            put_str(directed_cases[i]);
            send_text();
        end
        // Control bytes and the top code point, then a one-character string.
        text_q = '{8'h00, 8'hFF, 8'h80, CH_DASH};
        send_text();
        text_q = '{8'h7F};
        send_text();

        wait_drained();

        round = 0;
        while (chars_sent < CHAR_TARGET)
        begin
            make_random_stamp();
            send_text();
            round++;
            if (round == 6)
                hold_go = 1'b1;
            if (round % 12 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
